@@ hdl/afp_pkg.sv @@
// Shared types, codes and helper functions of the AM824 stream format parser.
package afp_pkg;

	// Byte values of the format block.
	localparam logic [7:0] HIER_AM824      = 8'h90;
	localparam logic [7:0] SUB_COMPOUND    = 8'h40;
	localparam logic [7:0] SUB_SIMPLE_A    = 8'h00;
	localparam logic [7:0] SUB_SIMPLE_B    = 8'h01;
	localparam logic [7:0] SUB_SIMPLE_C    = 8'h90;
	localparam logic [7:0] SYNC_MASK       = 8'h04;
	localparam logic [7:0] CODE_88K2       = 8'h0A;
	localparam logic [7:0] CODE_DONTCARE   = 8'h0F;
	localparam logic [7:0] MUSIC_44K1      = 8'h01;
	localparam logic [7:0] MUSIC_48K       = 8'h02;

	// Rate codes reported in a summary.
	localparam logic [3:0] RATE_44K1     = 4'd3;
	localparam logic [3:0] RATE_48K      = 4'd4;
	localparam logic [3:0] RATE_88K2     = 4'd8;
	localparam logic [3:0] RATE_DONTCARE = 4'd9;
	localparam logic [3:0] RATE_UNKNOWN  = 4'd10;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_TOO_SHORT = 2'd1,
		ST_BAD_HIER  = 2'd2,
		ST_BAD_SUB   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		SUB_NONE  = 2'd0,
		SUB_CMPD  = 2'd1,
		SUB_SMPL  = 2'd2,
		SUB_BAD   = 2'd3
	} sub_class_t;

	typedef enum logic {
		KIND_FIELD   = 1'b0,
		KIND_SUMMARY = 1'b1
	} item_kind_t;

	typedef enum logic {
		FMT_SIMPLE   = 1'b0,
		FMT_COMPOUND = 1'b1
	} format_kind_t;

	typedef struct packed {
		item_kind_t   item_kind;
		logic [7:0]   field_index;
		logic [7:0]   chan_count;
		logic [7:0]   fmt_code;
		status_t      status;
		format_kind_t format_kind;
		logic [3:0]   rate;
		logic         synchronized;
		logic [15:0]  total_channels;
		logic [7:0]   fields_parsed;
		logic         end_of_run;
	} result_t;

	// Push request from the parser into the result queue.
	typedef struct packed {
		logic [1:0] num;
		result_t    first;
		result_t    second;
	} push_t;

	function automatic logic [3:0] map_rate(input logic [7:0] code);
		logic [3:0] r;
		case (code) inside
			[8'h00:8'h07]: r = code[3:0];
			CODE_88K2:     r = RATE_88K2;
			CODE_DONTCARE: r = RATE_DONTCARE;
			default:       r = RATE_UNKNOWN;
		endcase
		return r;
	endfunction

	function automatic logic rate_missing(input logic [3:0] r);
		return (r == RATE_UNKNOWN) || (r == RATE_DONTCARE);
	endfunction

endpackage

@@ hdl/afp_if.sv @@
// Valid/ready channel interfaces for format block bytes and parser results.
interface afp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface afp_result_if;
	logic        valid;
	logic        ready;
	logic        item_kind;
	logic [7:0]  field_index;
	logic [7:0]  chan_count;
	logic [7:0]  fmt_code;
	logic [1:0]  status;
	logic        format_kind;
	logic [3:0]  rate;
	logic        synchronized;
	logic [15:0] total_channels;
	logic [7:0]  fields_parsed;
	logic        end_of_run;

	modport source (output valid, output item_kind, output field_index,
		output chan_count, output fmt_code, output status, output format_kind,
		output rate, output synchronized, output total_channels,
		output fields_parsed, output end_of_run, input ready);
	modport sink (input valid, input item_kind, input field_index,
		input chan_count, input fmt_code, input status, input format_kind,
		input rate, input synchronized, input total_channels,
		input fields_parsed, input end_of_run, output ready);
endinterface

@@ hdl/afp_result_fifo.sv @@
// Small result queue that takes up to two results a cycle and gives one.
module afp_result_fifo #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  afp_pkg::push_t   push,
	output logic             room2,
	output logic             head_valid,
	output afp_pkg::result_t head,
	input  logic             pop
);
	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	afp_pkg::result_t entry_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_p1;
	logic [CntW-1:0] count_q;
	logic            do_pop;

	function automatic logic [PtrW-1:0] inc(input logic [PtrW-1:0] p);
		return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wr_ptr_p1  = inc(wr_ptr_q);
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];
	assign room2      = (count_q <= CntW'(DEPTH - 2));
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			entry_q[wr_ptr_q] <= push.first;
		end
		if (push.num == 2'd2) begin
			entry_q[wr_ptr_p1] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			case (push.num)
				2'd1:    wr_ptr_q <= wr_ptr_p1;
				2'd2:    wr_ptr_q <= inc(wr_ptr_p1);
				default: wr_ptr_q <= wr_ptr_q;
			endcase
			if (do_pop) begin
				rd_ptr_q <= inc(rd_ptr_q);
			end
			count_q <= count_q + CntW'(push.num) - CntW'(do_pop);
		end
	end
endmodule

@@ hdl/am824_stream_format_parser.sv @@
// Top level of the AM824 stream format parser: byte decode, block state and result queue.
//
//   channel   | modport | transaction               | results per transaction
//   ----------+---------+---------------------------+------------------------
//   bytes     | sink    | one byte of a format blk  | -
//   results   | source  | one field or summary      | 0, 1 or 2 per byte
//
// One byte is taken per cycle while bytes.ready is high; its results land in the queue
// at the same edge and appear on results behind older entries. A final byte that closes a
// pair gives two results, which drain one per cycle while results.ready is high.
// bytes.ready is high while the queue has room for two entries, so a stall on results
// backs up into bytes only once the queue is nearly full. Reset clears the block state
// and empties the queue; the parser is then ready for byte 0 of a new block.
module am824_stream_format_parser #(
	parameter int MAX_BLOCK_BYTES = 1024,
	parameter int QUEUE_DEPTH     = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	afp_byte_if.sink      bytes,
	afp_result_if.source  results
);
	localparam int PosW = $clog2(MAX_BLOCK_BYTES + 1);

	// Block state, cleared at reset and after each last byte.
	logic [PosW-1:0]       pos_q;
	logic                  hier_q;
	afp_pkg::sub_class_t   sub_q;
	logic [7:0]            third_q;
	logic                  sync_q;
	logic [7:0]            fourth_q;
	logic [7:0]            sixth_q;
	logic [7:0]            pend_q;
	logic [7:0]            fcnt_q;
	logic [15:0]           sum_q;

	// Next values before end-of-block clearing.
	logic [PosW-1:0]       pos_n;
	logic                  hier_n;
	afp_pkg::sub_class_t   sub_n;
	logic [7:0]            third_n;
	logic                  sync_n;
	logic [7:0]            fourth_n;
	logic [7:0]            sixth_n;
	logic [7:0]            pend_n;
	logic [7:0]            fcnt_n;
	logic [15:0]           sum_n;

	logic                  accept;
	logic                  in_range;
	logic                  field_fire;
	logic                  room2;
	logic [7:0]            b;
	logic [3:0]            smpl_rate;
	afp_pkg::result_t      field_res;
	afp_pkg::result_t      summ_res;
	afp_pkg::result_t      head;
	afp_pkg::push_t        push;

	assign bytes.ready = room2;
	assign accept      = bytes.valid && bytes.ready;
	assign b           = bytes.data_byte;
	assign in_range    = (pos_q < PosW'(MAX_BLOCK_BYTES));

	// Decode the byte against its position; past the size limit, hold everything.
	always_comb begin
		pos_n      = pos_q;
		hier_n     = hier_q;
		sub_n      = sub_q;
		third_n    = third_q;
		sync_n     = sync_q;
		fourth_n   = fourth_q;
		sixth_n    = sixth_q;
		pend_n     = pend_q;
		fcnt_n     = fcnt_q;
		sum_n      = sum_q;
		field_fire = 1'b0;
		if (in_range) begin
			pos_n = pos_q + 1'b1;
			case (pos_q)
				PosW'(0): hier_n = (b == afp_pkg::HIER_AM824);
				PosW'(1): begin
					if (b == afp_pkg::SUB_COMPOUND) begin
						sub_n = afp_pkg::SUB_CMPD;
					end else if (b == afp_pkg::SUB_SIMPLE_A || b == afp_pkg::SUB_SIMPLE_B
						|| b == afp_pkg::SUB_SIMPLE_C) begin
						sub_n = afp_pkg::SUB_SMPL;
					end else begin
						sub_n = afp_pkg::SUB_BAD;
					end
				end
				PosW'(2): third_n  = b;
				PosW'(3): sync_n   = |(b & afp_pkg::SYNC_MASK);
				PosW'(4): fourth_n = b;
				default: begin
					if (pos_q == PosW'(5)) begin
						sixth_n = b;
					end
					// Compound pairs: odd position holds the count, even emits the pair.
					if (hier_q && sub_q == afp_pkg::SUB_CMPD) begin
						if (pos_q[0]) begin
							pend_n = b;
						end else if (fcnt_q < fourth_q) begin
							field_fire = 1'b1;
							fcnt_n     = fcnt_q + 8'd1;
							sum_n      = sum_q + {8'd0, pend_q};
						end
					end
				end
			endcase
		end
	end

	// Simple-form rate: byte 2 upper nibble, then music code, then byte 4 nibble.
	always_comb begin
		smpl_rate = afp_pkg::RATE_UNKNOWN;
		if (third_n[7:4] != 4'd0) begin
			smpl_rate = afp_pkg::map_rate({4'd0, third_n[7:4]});
		end
		if (afp_pkg::rate_missing(smpl_rate)) begin
			if (sixth_n == afp_pkg::MUSIC_44K1) begin
				smpl_rate = afp_pkg::RATE_44K1;
			end else if (sixth_n == afp_pkg::MUSIC_48K) begin
				smpl_rate = afp_pkg::RATE_48K;
			end
		end
		if (afp_pkg::rate_missing(smpl_rate) && fourth_n[7:4] != 4'd0) begin
			smpl_rate = afp_pkg::map_rate({4'd0, fourth_n[7:4]});
		end
	end

	always_comb begin
		field_res                = '0;
		field_res.item_kind      = afp_pkg::KIND_FIELD;
		field_res.field_index    = fcnt_q;
		field_res.chan_count     = pend_q;
		field_res.fmt_code       = b;
		field_res.status         = afp_pkg::ST_OK;
		field_res.format_kind    = afp_pkg::FMT_COMPOUND;
		field_res.rate           = afp_pkg::RATE_UNKNOWN;
		field_res.end_of_run     = !bytes.last_byte;

		summ_res                 = '0;
		summ_res.item_kind       = afp_pkg::KIND_SUMMARY;
		summ_res.status          = afp_pkg::ST_OK;
		summ_res.format_kind     = afp_pkg::FMT_SIMPLE;
		summ_res.rate            = afp_pkg::RATE_UNKNOWN;
		summ_res.end_of_run      = 1'b1;
		if (pos_n < PosW'(2)) begin
			summ_res.status = afp_pkg::ST_TOO_SHORT;
		end else if (!hier_n) begin
			summ_res.status = afp_pkg::ST_BAD_HIER;
		end else if (sub_n == afp_pkg::SUB_CMPD) begin
			if (pos_n < PosW'(5)) begin
				summ_res.status = afp_pkg::ST_TOO_SHORT;
			end else begin
				summ_res.format_kind    = afp_pkg::FMT_COMPOUND;
				summ_res.rate           = afp_pkg::map_rate(third_n);
				summ_res.synchronized   = sync_n;
				summ_res.total_channels = sum_n;
				summ_res.fields_parsed  = fcnt_n;
			end
		end else if (sub_n == afp_pkg::SUB_SMPL) begin
			if (pos_n < PosW'(3)) begin
				summ_res.status = afp_pkg::ST_TOO_SHORT;
			end else begin
				summ_res.total_channels = 16'd2;
				summ_res.rate = (pos_n >= PosW'(6)) ? smpl_rate : afp_pkg::RATE_DONTCARE;
			end
		end else begin
			summ_res.status = afp_pkg::ST_BAD_SUB;
		end
	end

	// Queue the field result first, then the summary if this byte ends the block.
	always_comb begin
		push.num    = 2'd0;
		push.first  = field_fire ? field_res : summ_res;
		push.second = summ_res;
		if (accept) begin
			push.num = {1'b0, field_fire} + {1'b0, bytes.last_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			hier_q   <= 1'b0;
			sub_q    <= afp_pkg::SUB_NONE;
			third_q  <= '0;
			sync_q   <= 1'b0;
			fourth_q <= '0;
			sixth_q  <= '0;
			pend_q   <= '0;
			fcnt_q   <= '0;
			sum_q    <= '0;
		end else if (accept) begin
			if (bytes.last_byte) begin
				// Drop the block and start over at byte 0.
				pos_q    <= '0;
				hier_q   <= 1'b0;
				sub_q    <= afp_pkg::SUB_NONE;
				third_q  <= '0;
				sync_q   <= 1'b0;
				fourth_q <= '0;
				sixth_q  <= '0;
				pend_q   <= '0;
				fcnt_q   <= '0;
				sum_q    <= '0;
			end else begin
				pos_q    <= pos_n;
				hier_q   <= hier_n;
				sub_q    <= sub_n;
				third_q  <= third_n;
				sync_q   <= sync_n;
				fourth_q <= fourth_n;
				sixth_q  <= sixth_n;
				pend_q   <= pend_n;
				fcnt_q   <= fcnt_n;
				sum_q    <= sum_n;
			end
		end
	end

	afp_result_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.room2      (room2),
		.head_valid (results.valid),
		.head       (head),
		.pop        (results.ready)
	);

	assign results.item_kind      = head.item_kind;
	assign results.field_index    = head.field_index;
	assign results.chan_count     = head.chan_count;
	assign results.fmt_code       = head.fmt_code;
	assign results.status         = head.status;
	assign results.format_kind    = head.format_kind;
	assign results.rate           = head.rate;
	assign results.synchronized   = head.synchronized;
	assign results.total_channels = head.total_channels;
	assign results.fields_parsed  = head.fields_parsed;
	assign results.end_of_run     = head.end_of_run;
endmodule

@@ tb/sv/format_result_checker.sv @@
// Checker for the AM824 format parser: predicts results from accepted bytes and compares them.
module format_result_checker #(
	parameter int MAX_BLOCK_BYTES = 1024
) (
	input  logic  clk,
	input  logic  arst_n,
	afp_byte_if   bytes,
	afp_result_if results,
	output int    fail_count,
	output int    outstanding,
	output int    results_checked
);
	import afp_pkg::*;

	// Block state of the predictor.
	int unsigned blk_pos;
	logic        hier_ok;
	sub_class_t  sub_class;
	logic [7:0]  rate_byte;
	logic        sync_bit;
	logic [7:0]  pair_limit;
	logic [7:0]  music_code;
	logic [7:0]  pair_first;
	logic [7:0]  pairs_done;
	logic [15:0] channel_total;

	result_t expected_results[$];
	int      mismatches = 0;
	int      checked = 0;

	function automatic logic [3:0] rate_from_code(input logic [7:0] code);
		if (code < 8'h08)
			return code[3:0];
		if (code == CODE_88K2)
			return RATE_88K2;
		if (code == CODE_DONTCARE)
			return RATE_DONTCARE;
		return RATE_UNKNOWN;
	endfunction

	function automatic logic rate_unresolved(input logic [3:0] r);
		return (r == RATE_UNKNOWN) || (r == RATE_DONTCARE);
	endfunction

	task automatic clear_block();
		blk_pos       = 0;
		hier_ok       = 1'b0;
		sub_class     = SUB_NONE;
		rate_byte     = 8'h00;
		sync_bit      = 1'b0;
		pair_limit    = 8'h00;
		music_code    = 8'h00;
		pair_first    = 8'h00;
		pairs_done    = 8'h00;
		channel_total = 16'h0000;
	endtask

	task automatic report(input string msg);
		$display("[%0t] MISMATCH %s", $time, msg);
		mismatches++;
	endtask

	task automatic compare_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report($sformatf("result %0d %s: got 0x%0h, want 0x%0h", checked, name, got, want));
	endtask

	// Advance the block by one byte and queue whatever results it causes.
	task automatic parse_expected(input logic [7:0] b, input logic fin);
		result_t     r;
		int unsigned len;
		logic [3:0]  rate;
		if (blk_pos < MAX_BLOCK_BYTES) begin
			case (blk_pos)
				0: hier_ok = (b == HIER_AM824);
				1: begin
					if (b == SUB_COMPOUND)
						sub_class = SUB_CMPD;
					else if (b == SUB_SIMPLE_A || b == SUB_SIMPLE_B || b == SUB_SIMPLE_C)
						sub_class = SUB_SMPL;
					else
						sub_class = SUB_BAD;
				end
				2: rate_byte = b;
				3: sync_bit = (b & SYNC_MASK) != 8'h00;
				4: pair_limit = b;
				default: begin
					if (blk_pos == 5)
						music_code = b;
					if (hier_ok && sub_class == SUB_CMPD) begin
						if (blk_pos[0]) begin
							pair_first = b;
						end else if (pairs_done < pair_limit) begin
							r = '0;
							r.item_kind     = KIND_FIELD;
							r.field_index   = pairs_done;
							r.chan_count    = pair_first;
							r.fmt_code      = b;
							r.status        = ST_OK;
							r.format_kind   = FMT_COMPOUND;
							r.rate          = RATE_UNKNOWN;
							r.end_of_run    = !fin;
							expected_results = {expected_results, r};
							pairs_done++;
							channel_total += {8'h00, pair_first};
						end
					end
				end
			endcase
			blk_pos++;
		end
		if (fin) begin
			len = blk_pos;
			r = '0;
			r.item_kind   = KIND_SUMMARY;
			r.status      = ST_OK;
			r.format_kind = FMT_SIMPLE;
			r.rate        = RATE_UNKNOWN;
			r.end_of_run  = 1'b1;
			if (len < 2) begin
				r.status = ST_TOO_SHORT;
			end else if (!hier_ok) begin
				r.status = ST_BAD_HIER;
			end else if (sub_class == SUB_CMPD) begin
				if (len < 5) begin
					r.status = ST_TOO_SHORT;
				end else begin
					r.format_kind    = FMT_COMPOUND;
					r.rate           = rate_from_code(rate_byte);
					r.synchronized   = sync_bit;
					r.total_channels = channel_total;
					r.fields_parsed  = pairs_done;
				end
			end else if (sub_class == SUB_SMPL) begin
				if (len < 3) begin
					r.status = ST_TOO_SHORT;
				end else begin
					r.total_channels = 16'd2;
					if (len < 6) begin
						r.rate = RATE_DONTCARE;
					end else begin
						rate = RATE_UNKNOWN;
						if (rate_byte[7:4] != 4'h0)
							rate = rate_from_code({4'h0, rate_byte[7:4]});
						if (rate_unresolved(rate)) begin
							if (music_code == MUSIC_44K1)
								rate = RATE_44K1;
							else if (music_code == MUSIC_48K)
								rate = RATE_48K;
						end
						if (rate_unresolved(rate) && pair_limit[7:4] != 4'h0)
							rate = rate_from_code({4'h0, pair_limit[7:4]});
						r.rate = rate;
					end
				end
			end else begin
				r.status = ST_BAD_SUB;
			end
			expected_results = {expected_results, r};
			clear_block();
		end
	endtask

	task automatic check_result();
		result_t got;
		result_t want;
		got = {results.item_kind, results.field_index, results.chan_count,
			results.fmt_code, results.status, results.format_kind, results.rate,
			results.synchronized, results.total_channels, results.fields_parsed,
			results.end_of_run};
		checked++;
		if (expected_results.size() == 0) begin
			report($sformatf("result %0d arrived with nothing expected", checked));
		end else begin
			want = expected_results.pop_front();
			compare_field("item_kind", got.item_kind, want.item_kind);
			compare_field("field_index", got.field_index, want.field_index);
			compare_field("chan_count", got.chan_count, want.chan_count);
			compare_field("fmt_code", got.fmt_code, want.fmt_code);
			compare_field("status", got.status, want.status);
			compare_field("format_kind", got.format_kind, want.format_kind);
			compare_field("rate", got.rate, want.rate);
			compare_field("synchronized", got.synchronized, want.synchronized);
			compare_field("total_channels", got.total_channels, want.total_channels);
			compare_field("fields_parsed", got.fields_parsed, want.fields_parsed);
			compare_field("end_of_run", got.end_of_run, want.end_of_run);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_block();
			expected_results.delete();
			fail_count      <= 0;
			outstanding     <= 0;
			results_checked <= 0;
		end else begin
			if (results.valid && results.ready)
				check_result();
			if (bytes.valid && bytes.ready)
				parse_expected(bytes.data_byte, bytes.last_byte);
			fail_count      <= mismatches;
			outstanding     <= expected_results.size();
			results_checked <= checked;
		end
	end

endmodule

@@ tb/sv/testbench.sv @@
// Testbench top for the AM824 format parser: clock, reset, byte stimulus, back-pressure, verdict.
module testbench;
	import afp_pkg::*;

	localparam int BLOCK_BYTES_MAX  = 1024;
	localparam int RANDOM_BYTES     = 1700;
	localparam int LONG_BLOCK_BYTES = BLOCK_BYTES_MAX + 6;
	localparam int STALL_LIMIT      = 2000;
	localparam int IDLE_PCT         = 14;

	logic clk = 1'b0;
	logic arst_n;

	int idle_pct = IDLE_PCT;
	int stall_cycles = 0;
	int fail_count;
	int outstanding;
	int results_checked;
	int blocks_sent = 0;
	int bytes_sent = 0;

	// Bytes of the block about to be sent.
	logic [7:0] block_q[$];

	afp_byte_if   byte_ch();
	afp_result_if res_ch();

	am824_stream_format_parser #(
		.MAX_BLOCK_BYTES(BLOCK_BYTES_MAX)
	) dut (
		.clk,
		.arst_n,
		.bytes  (byte_ch),
		.results(res_ch)
	);

	format_result_checker #(
		.MAX_BLOCK_BYTES(BLOCK_BYTES_MAX)
	) result_check (
		.clk,
		.arst_n,
		.bytes          (byte_ch),
		.results        (res_ch),
		.fail_count     (fail_count),
		.outstanding    (outstanding),
		.results_checked(results_checked)
	);

	always #10 clk = ~clk;

	// Stall the result side at random; idle_pct drops to zero during the calm stretch.
	always @(posedge clk) begin
		res_ch.ready <= ($urandom_range(99) >= idle_pct);
	end

	// Count cycles with no transaction on either channel; give up when the count hits the limit.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("no transaction for %0d cycles, %0d results still expected",
					stall_cycles, outstanding);
				$display("FAIL am824_stream_format_parser");
				$finish;
			end
		end
	end

	// Offer one byte, with random idle cycles in front, and hold it until the parser takes it.
	task automatic send_byte(input logic [7:0] b, input logic fin);
		while ($urandom_range(99) < idle_pct) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid     <= 1'b1;
		byte_ch.data_byte <= b;
		byte_ch.last_byte <= fin;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	// Send block_q, flagging its final byte.
	task automatic send_block();
		foreach (block_q[i])
			send_byte(block_q[i], i == block_q.size() - 1);
		blocks_sent++;
	endtask

	// Drop valid and hold off until every expected result has drained.
	task automatic drain_results();
		byte_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// Append one byte to the block under construction.
	task automatic add_byte(input logic [7:0] v);
		block_q = {block_q, v};
	endtask

	// Compound block: header, announced pair count, then pairs and maybe a lone trailing byte.
	task automatic build_compound(input int announced, input int pairs, input bit odd_tail);
		int pick;
		block_q = '{HIER_AM824, SUB_COMPOUND};
		pick = $urandom_range(11);
		// Mostly a listed rate code, sometimes anything.
		if (pick < 8)
			add_byte(8'(pick));
		else if (pick == 8)
			add_byte(CODE_88K2);
		else if (pick == 9)
			add_byte(CODE_DONTCARE);
		else
			add_byte(8'($urandom));
		add_byte(8'($urandom));
		add_byte(8'(announced));
		repeat (pairs) begin
			pick = $urandom_range(9);
			add_byte((pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom));
			add_byte(8'($urandom));
		end
		if (odd_tail)
			add_byte(8'($urandom));
	endtask

	// Simple block of 2 to 8 bytes; bias the nibbles and the music code toward the rate fallbacks.
	task automatic build_simple();
		int extra;
		int i;
		int pick;
		pick = $urandom_range(2);
		block_q = '{HIER_AM824,
			(pick == 0) ? SUB_SIMPLE_A : (pick == 1) ? SUB_SIMPLE_B : SUB_SIMPLE_C};
		extra = $urandom_range(6);
		for (i = 0; i < extra; i++) begin
			pick = $urandom_range(9);
			case (i)
				0, 2: add_byte((pick < 3) ? {4'h0, 4'($urandom)} : 8'($urandom));
				3: add_byte((pick < 3) ? MUSIC_44K1 : (pick < 6) ? MUSIC_48K :
					8'($urandom));
				default: add_byte(8'($urandom));
			endcase
		end
	endtask

	// Noise: short random blocks, half of them with a correct first byte.
	task automatic build_noise();
		int len;
		len = $urandom_range(1, 8);
		block_q.delete();
		repeat (len)
			add_byte(8'($urandom));
		if ($urandom_range(1) == 0)
			block_q[0] = HIER_AM824;
	endtask

	initial begin
		int blk_no;
		int pick;
		int announced;
		int pairs;
		int random_start;

		byte_ch.valid     <= 1'b0;
		byte_ch.data_byte <= 8'h00;
		byte_ch.last_byte <= 1'b0;
		arst_n            <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed blocks: every error class, both forms and the short simple form.
		block_q = '{HIER_AM824};                                   // one byte: too short
		send_block();
		block_q = '{8'h00, SUB_COMPOUND};                          // wrong hierarchy byte
		send_block();
		block_q = '{HIER_AM824, 8'h41};                            // unknown subtype
		send_block();
		block_q = '{HIER_AM824, SUB_COMPOUND, 8'h04};              // compound cut short
		send_block();
		block_q = '{HIER_AM824, SUB_SIMPLE_B};                     // simple, two bytes
		send_block();
		block_q = '{HIER_AM824, SUB_SIMPLE_C, 8'hFF};              // simple, rate don't care
		send_block();
		// Compound, sync set, two pairs; the final byte closes a pair and gives two results.
		block_q = '{HIER_AM824, SUB_COMPOUND, CODE_88K2, SYNC_MASK, 8'h02,
			8'hFF, 8'h40, 8'h00, 8'h06};
		send_block();
		// Simple, six bytes: zero nibble in byte 2, so the music code picks the rate.
		block_q = '{HIER_AM824, SUB_SIMPLE_A, 8'h0F, 8'h00, 8'hF0, MUSIC_48K};
		send_block();
		drain_results();

		// Random blocks: mostly well-formed compound lists, also simple blocks and noise.
		random_start = bytes_sent;
		blk_no = 0;
		while (bytes_sent - random_start < RANDOM_BYTES) begin
			blk_no++;
			if (blk_no == 35)
				idle_pct <= 0;
			else if (blk_no == 55)
				idle_pct <= IDLE_PCT;
			if (blk_no == 20) begin
				// Over-long list: 255 fields announced and the block runs past the byte limit.
				build_compound(255, (LONG_BLOCK_BYTES - 5) / 2, 1'b1);
			end else begin
				pick = $urandom_range(99);
				if (pick < 55) begin
					announced = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
					pairs = announced + $urandom_range(3) - 1;
					if (pairs < 0)
						pairs = 0;
					build_compound(announced, pairs, $urandom_range(3) == 0);
				end else if (pick < 85) begin
					build_simple();
				end else begin
					build_noise();
				end
			end
			send_block();
			if (blk_no % 15 == 0)
				drain_results();
		end

		// Let the last results drain before the verdict.
		drain_results();
		repeat (8) @(posedge clk);

		$display("Sent %0d blocks in %0d bytes: both forms, all error classes, pair limits,",
			blocks_sent, bytes_sent);
		$display("a 255-field list past the byte limit; %0d results checked.", results_checked);
		if (fail_count == 0 && outstanding == 0)
			$display("PASS am824_stream_format_parser");
		else
			$display("FAIL am824_stream_format_parser");
		$finish;
	end

endmodule
